>>> sv/dce_pkg.sv
// Shared types and constants of the daisy-chain position enumerator.
package dce_pkg;

    // Kind of an input transaction.
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_DEBOUNCE_TICKS  = 2'd0;
    localparam logic [1:0] CFG_OUT_DELAY_TICKS = 2'd1;
    localparam logic [1:0] CFG_MAX_INDEX       = 2'd2;

    // Phase codes as they appear on the result.
    localparam logic [1:0] PHASE_WAIT     = 2'd0;
    localparam logic [1:0] PHASE_DEBOUNCE = 2'd1;
    localparam logic [1:0] PHASE_ASSIGNED = 2'd2;
    localparam logic [1:0] PHASE_DONE     = 2'd3;

    // A peer index of all ones means that no peer has been heard.
    localparam logic [7:0] PEER_NONE = 8'hFF;

    // Reset values of the configuration registers.
    localparam logic [7:0] DEBOUNCE_TICKS_RST  = 8'd5;
    localparam logic [7:0] OUT_DELAY_TICKS_RST = 8'd5;
    localparam logic [7:0] MAX_INDEX_RST       = 8'd254;

    typedef struct packed {
        logic [7:0] debounce_ticks;
        logic [7:0] out_delay_ticks;
        logic [7:0] max_index;
    } t_cfg;

    typedef struct packed {
        logic       operation;
        logic       line_in;
        logic [7:0] peer_index;
    } t_item;

    typedef struct packed {
        logic [1:0] phase_now;
        logic [7:0] assigned_index;
        logic       unenumerated;
        logic       chain_out;
    } t_result;

endpackage

>>> sv/dce_cfg_regs.sv
// Configuration registers of the daisy-chain position enumerator.
module dce_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output dce_pkg::t_cfg o_cfg
);
    import dce_pkg::*;

    t_cfg r_cfg;

    // Write decode; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= DEBOUNCE_TICKS_RST;
            r_cfg.out_delay_ticks <= OUT_DELAY_TICKS_RST;
            r_cfg.max_index       <= MAX_INDEX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TICKS:  r_cfg.debounce_ticks  <= i_cfg_data;
                CFG_OUT_DELAY_TICKS: r_cfg.out_delay_ticks <= i_cfg_data;
                CFG_MAX_INDEX:       r_cfg.max_index       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/dce_core.sv
// Enumeration state machine: peer latch, debounce, index claim and output delay.
module dce_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dce_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  dce_pkg::t_item   i_item,
    output dce_pkg::t_result o_result
);
    import dce_pkg::*;

    typedef enum logic [1:0] {
        ST_WAIT     = 2'd0,
        ST_DEBOUNCE = 2'd1,
        ST_ASSIGNED = 2'd2,
        ST_DONE     = 2'd3
    } t_state;

    t_state     r_phase, n_phase;
    logic [7:0] r_deb_cnt, n_deb_cnt;
    logic [7:0] r_dly_cnt, n_dly_cnt;
    logic [7:0] r_highest, n_highest;
    logic [7:0] r_latched, n_latched;
    logic       r_latch_valid, n_latch_valid;
    logic [7:0] r_own, n_own;
    logic       r_unenum, n_unenum;
    logic       r_out_level, n_out_level;
    logic [7:0] deb_inc;
    logic [7:0] dly_inc;

    assign deb_inc = r_deb_cnt + 8'd1;
    assign dly_inc = r_dly_cnt + 8'd1;

    // Next state for one transaction.
    always_comb begin
        n_phase       = r_phase;
        n_deb_cnt     = r_deb_cnt;
        n_dly_cnt     = r_dly_cnt;
        n_highest     = r_highest;
        n_latched     = r_latched;
        n_latch_valid = r_latch_valid;
        n_own         = r_own;
        n_unenum      = r_unenum;
        n_out_level   = r_out_level;
        if (i_item.operation == OP_TICK) begin
            // Fold the latched report into the highest peer first.
            if (r_latch_valid && r_phase != ST_DONE) begin
                n_latch_valid = 1'b0;
                if (r_highest == PEER_NONE || r_latched > r_highest) begin
                    n_highest = r_latched;
                end
            end
            case (r_phase)
                ST_WAIT: begin
                    if (i_item.line_in) begin
                        n_deb_cnt = 8'd1;
                        n_phase   = ST_DEBOUNCE;
                    end
                end
                ST_DEBOUNCE: begin
                    if (!i_item.line_in) begin
                        n_deb_cnt = 8'd0;
                        n_phase   = ST_WAIT;
                    end else begin
                        n_deb_cnt = deb_inc;
                        if (deb_inc >= i_cfg.debounce_ticks) begin
                            if (n_highest == PEER_NONE || n_highest < i_cfg.max_index) begin
                                n_own     = (n_highest == PEER_NONE) ? 8'd0
                                                                     : n_highest + 8'd1;
                                n_unenum  = 1'b0;
                                n_dly_cnt = 8'd0;
                                n_phase   = ST_ASSIGNED;
                            end else begin
                                // The chain is full: no index can be claimed.
                                n_unenum  = 1'b1;
                                n_deb_cnt = 8'd0;
                                n_phase   = ST_WAIT;
                            end
                        end
                    end
                end
                ST_ASSIGNED: begin
                    n_dly_cnt = dly_inc;
                    if (dly_inc >= i_cfg.out_delay_ticks) begin
                        n_out_level = 1'b1;
                        n_phase     = ST_DONE;
                    end
                end
                default: ;
            endcase
        end else if (r_phase != ST_DONE && i_item.peer_index != PEER_NONE) begin
            // Keep the largest report seen since the last tick.
            if (!r_latch_valid || i_item.peer_index > r_latched) begin
                n_latched = i_item.peer_index;
            end
            n_latch_valid = 1'b1;
        end
    end

    // State registers advance once per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ST_WAIT;
            r_deb_cnt     <= 8'd0;
            r_dly_cnt     <= 8'd0;
            r_highest     <= PEER_NONE;
            r_latched     <= PEER_NONE;
            r_latch_valid <= 1'b0;
            r_own         <= 8'd0;
            r_unenum      <= 1'b1;
            r_out_level   <= 1'b0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_deb_cnt     <= n_deb_cnt;
            r_dly_cnt     <= n_dly_cnt;
            r_highest     <= n_highest;
            r_latched     <= n_latched;
            r_latch_valid <= n_latch_valid;
            r_own         <= n_own;
            r_unenum      <= n_unenum;
            r_out_level   <= n_out_level;
        end
    end

    // The result shows the state after the transaction.
    assign o_result.phase_now      = n_phase;
    assign o_result.assigned_index = n_own;
    assign o_result.unenumerated   = n_unenum;
    assign o_result.chain_out      = n_out_level;

endmodule

>>> sv/daisy_chain_enumerator_top.sv
// Top level of the daisy-chain position enumerator.
//
// Input channel: i_in_valid / o_in_stall with fields i_operation, i_line_in and
// i_peer_index. A tick transaction advances the enumeration controller; a peer
// report transaction latches a neighbour's chain index until the next tick.
// Output channel: o_out_valid / i_out_stall with one result transaction per
// input transaction: phase, claimed index, not-enumerated flag and enable-out.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the
// user must write it only while the block is idle, which the block itself does
// not enforce; it takes effect at once. An accepted transaction waits in the
// input register until the state update loads the result register.
// Throughput is one transaction per cycle while the receiver does not stall.
// While the receiver stalls, the result register holds; one more transaction is
// held in the input register, after which o_in_stall rises.
// Reset is synchronous and active low; it empties both registers, restores the
// register defaults and returns the controller to the wait phase.
module daisy_chain_enumerator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_operation,
    input  logic       i_line_in,
    input  logic [7:0] i_peer_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_phase_now,
    output logic [7:0] o_assigned_index,
    output logic       o_unenumerated,
    output logic       o_chain_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import dce_pkg::*;

    t_cfg    cfg;
    t_result core_result;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out_result;
    logic    r_out_valid;
    logic    out_free;
    logic    fire;
    logic    in_take;

    dce_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dce_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // Handshake: the held transaction moves on when the result register is free.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.operation  <= i_operation;
            r_in_item.line_in    <= i_line_in;
            r_in_item.peer_index <= i_peer_index;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_result <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_phase_now      = r_out_result.phase_now;
    assign o_assigned_index = r_out_result.assigned_index;
    assign o_unenumerated   = r_out_result.unenumerated;
    assign o_chain_out      = r_out_result.chain_out;

    // Enable-out is only driven once the done phase has been reached.
    a_chain_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_chain_out |-> o_phase_now == PHASE_DONE)
        else $error("enable-out high outside the done phase");

    // A claimed index keeps the controller in the assigned or done phase.
    a_claim_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_unenumerated |->
            o_phase_now == PHASE_ASSIGNED || o_phase_now == PHASE_DONE)
        else $error("index claimed but phase is wait or debounce");

    // Back-pressure only when both registers are occupied and the receiver stalls.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with a free register");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule
